/* hw/rtl/qkp_pkg.sv */
package qkp_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 40;

	localparam logic [CFG_INDEX_W-1:0] REG_RING_PIXELS     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_POSITION = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ANSWER_BAND     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_STEP       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_STRENGTH_TABLE  = 3'd4;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_LOAD   = 1'b1;

	// Transitions as {previous phase, new phase}.
	localparam logic [3:0] STEP_UP_0   = 4'b1101;
	localparam logic [3:0] STEP_UP_1   = 4'b0100;
	localparam logic [3:0] STEP_UP_2   = 4'b0010;
	localparam logic [3:0] STEP_UP_3   = 4'b1011;
	localparam logic [3:0] STEP_DOWN_0 = 4'b1110;
	localparam logic [3:0] STEP_DOWN_1 = 4'b0111;
	localparam logic [3:0] STEP_DOWN_2 = 4'b0001;
	localparam logic [3:0] STEP_DOWN_3 = 4'b1000;

	localparam int RINGS = 3;
	localparam int STEPS_PER_DETENT = 4;
	localparam logic [9:0] COUNT_LIMIT = 10'd1023;

	typedef struct packed {
		logic       mode;
		logic       pin_a;
		logic       pin_b;
		logic [9:0] preset_count;
		logic       clear_phase;
	} qkp_in_t;

	typedef struct packed {
		logic [9:0] raw_count;
		logic [7:0] detent_value;
		logic [1:0] revolution;
		logic [5:0] lit_pixel;
		logic [2:0] vibration_level;
		logic [7:0] vibration_duty;
	} qkp_out_t;

	typedef struct packed {
		logic [6:0]  ring;
		logic [7:0]  ring2;
		logic [8:0]  ring3;
		logic [9:0]  maxc;
		logic [7:0]  target;
		logic [9:0]  th0;
		logic [9:0]  th1;
		logic [9:0]  th2;
		logic [9:0]  th3;
		logic [39:0] strength;
	} qkp_cfg_t;

endpackage

/* hw/rtl/qkp_in_if.sv */
interface qkp_in_if import qkp_pkg::*; ();
	logic    valid;
	logic    ready;
	qkp_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/qkp_out_if.sv */
interface qkp_out_if import qkp_pkg::*; ();
	logic     valid;
	logic     ready;
	qkp_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/qkp_counter.sv */
module qkp_counter import qkp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       update,
	input  qkp_in_t    item,
	input  logic [9:0] maxc,
	output logic [9:0] count
);

	logic [9:0]  count_q;
	logic [1:0]  phase_q;
	logic [3:0]  trans;
	logic [10:0] stepped;
	logic [10:0] count_next;
	logic [1:0]  phase_next;

	assign trans = {phase_q, item.pin_a, item.pin_b};

	always_comb begin
		stepped = {1'b0, count_q};
		case (trans)
			STEP_UP_0, STEP_UP_1, STEP_UP_2, STEP_UP_3: begin
				stepped = {1'b0, count_q} + 11'd1;
			end
			STEP_DOWN_0, STEP_DOWN_1, STEP_DOWN_2, STEP_DOWN_3: begin
				if (count_q != 10'd0) begin
					stepped = {1'b0, count_q} - 11'd1;
				end
			end
			default: begin
				stepped = {1'b0, count_q};
			end
		endcase
	end

	always_comb begin
		if (item.mode == MODE_LOAD) begin
			count_next = {1'b0, item.preset_count};
			phase_next = item.clear_phase ? 2'b00 : phase_q;
		end else begin
			count_next = stepped;
			phase_next = {item.pin_a, item.pin_b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
		end else if (update) begin
			count_q <= (count_next > {1'b0, maxc}) ? maxc : count_next[9:0];
			phase_q <= phase_next;
		end
	end

	assign count = count_q;

endmodule

/* hw/rtl/qkp_readout.sv */
module qkp_readout import qkp_pkg::*; (
	input  logic [9:0] count,
	input  qkp_cfg_t   cfg,
	output qkp_out_t   view
);

	logic [7:0] quarter;
	logic [8:0] q9;
	logic [8:0] lit9;
	logic [7:0] diff;
	logic [9:0] diff10;

	assign quarter = count[9:2];
	assign q9      = {1'b0, quarter};
	assign diff    = (cfg.target > quarter) ? cfg.target - quarter : quarter - cfg.target;
	assign diff10  = {2'b00, diff};

	always_comb begin
		view           = '0;
		view.raw_count = count;
		lit9           = '0;
		if (q9 < {2'b00, cfg.ring}) begin
			view.detent_value = quarter;
			view.revolution   = 2'd1;
			lit9              = {2'b00, cfg.ring} - 9'd1 - q9;
		end else if (q9 < {1'b0, cfg.ring2}) begin
			view.detent_value = quarter;
			view.revolution   = 2'd2;
			lit9              = {1'b0, cfg.ring2} - 9'd1 - q9;
		end else if (q9 < cfg.ring3) begin
			view.detent_value = quarter;
			view.revolution   = 2'd3;
			lit9              = cfg.ring3 - 9'd1 - q9;
		end else begin
			view.detent_value = 8'(cfg.ring3 - 9'd1);
			view.revolution   = 2'd3;
			lit9              = '0;
		end
		view.lit_pixel = lit9[5:0];

		if (diff10 < cfg.th0) begin
			view.vibration_level = 3'd0;
		end else if (diff10 < cfg.th1) begin
			view.vibration_level = 3'd1;
		end else if (diff10 < cfg.th2) begin
			view.vibration_level = 3'd2;
		end else if (diff10 < cfg.th3) begin
			view.vibration_level = 3'd3;
		end else begin
			view.vibration_level = 3'd4;
		end

		case (view.vibration_level)
			3'd0:    view.vibration_duty = cfg.strength[7:0];
			3'd1:    view.vibration_duty = cfg.strength[15:8];
			3'd2:    view.vibration_duty = cfg.strength[23:16];
			3'd3:    view.vibration_duty = cfg.strength[31:24];
			default: view.vibration_duty = cfg.strength[39:32];
		endcase
	end

endmodule

/* hw/rtl/quadrature_knob_position_tracker.sv */
// Path: an accepted item passes the input, count and output registers in turn.
// Throughput: one item per cycle unless out_ch.ready stalls it; the count register is
// updated once per item as it leaves the input register, so items follow back to back.
// Reset: arst_n clears the count, the stored phase and all valid flags, and
// restores the configuration registers to their documented defaults.
module quadrature_knob_position_tracker import qkp_pkg::*; #(
	parameter int MAX_RING_PIXELS = 64,
	parameter int DUTY_BITS       = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	qkp_in_if.sink                 in_ch,
	qkp_out_if.source              out_ch
);

	localparam logic [7:0] DUTY_MASK =
		(DUTY_BITS >= 8) ? 8'hFF : 8'((17'd1 << DUTY_BITS) - 17'd1);

	localparam qkp_cfg_t CFG_RESET = '{
		ring: 7'd24, ring2: 8'd48, ring3: 9'd72, maxc: 10'd288, target: 8'd0,
		th0: 10'd2, th1: 10'd7, th2: 10'd12, th3: 10'd17, strength: 40'd0
	};

	logic [6:0]  ring_pixels_q;
	logic [7:0]  target_q;
	logic [7:0]  answer_q;
	logic [7:0]  step_q;
	logic [39:0] strength_q;
	qkp_cfg_t    cfg_q;
	qkp_cfg_t    cfg_next;
	logic [6:0]  ring_eff;
	logic [10:0] ring12;

	logic       valid_s1;
	qkp_in_t    item_s1;
	logic       valid_s2;
	logic       valid_s3;
	qkp_out_t   out_s3;
	logic       adv2;
	logic       adv3;
	logic       in_take;
	logic       update;
	logic [9:0] count;
	qkp_out_t   view;
	qkp_out_t   view_masked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_pixels_q <= 7'd24;
			target_q      <= 8'd0;
			answer_q      <= 8'd2;
			step_q        <= 8'd5;
			strength_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RING_PIXELS:     ring_pixels_q <= cfg_data[6:0];
				REG_TARGET_POSITION: target_q      <= cfg_data[7:0];
				REG_ANSWER_BAND:     answer_q      <= cfg_data[7:0];
				REG_BAND_STEP:       step_q        <= cfg_data[7:0];
				REG_STRENGTH_TABLE:  strength_q    <= cfg_data[39:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (ring_pixels_q == 7'd0) begin
			ring_eff = 7'd1;
		end else if ({2'b00, ring_pixels_q} > 9'(MAX_RING_PIXELS)) begin
			ring_eff = 7'(MAX_RING_PIXELS);
		end else begin
			ring_eff = ring_pixels_q;
		end
		ring12            = 11'({ring_eff, 3'b000}) + 11'({ring_eff, 2'b00});
		cfg_next.ring     = ring_eff;
		cfg_next.ring2    = {ring_eff, 1'b0};
		cfg_next.ring3    = 9'({ring_eff, 1'b0}) + 9'(ring_eff);
		cfg_next.maxc     = (ring12 > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : ring12[9:0];
		cfg_next.target   = target_q;
		cfg_next.th0      = {2'b00, answer_q};
		cfg_next.th1      = {2'b00, answer_q} + {2'b00, step_q};
		cfg_next.th2      = {2'b00, answer_q} + {1'b0, step_q, 1'b0};
		cfg_next.th3      = {2'b00, answer_q} + {1'b0, step_q, 1'b0} + {2'b00, step_q};
		cfg_next.strength = strength_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else begin
			cfg_q <= cfg_next;
		end
	end

	assign adv3         = !valid_s3 || out_ch.ready;
	assign adv2         = !valid_s2 || adv3;
	assign in_ch.ready  = !valid_s1 || adv2;
	assign in_take      = in_ch.valid && in_ch.ready;
	assign update       = valid_s1 && adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !adv2);
			valid_s2 <= update || (valid_s2 && !adv3);
			valid_s3 <= (valid_s2 && adv3) || (valid_s3 && !out_ch.ready);
		end
	end

	always_comb begin
		view_masked                = view;
		view_masked.vibration_duty = view.vibration_duty & DUTY_MASK;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_ch.data;
		end
		if (valid_s2 && adv3) begin
			out_s3 <= view_masked;
		end
	end

	qkp_counter u_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.update (update),
		.item   (item_s1),
		.maxc   (cfg_q.maxc),
		.count  (count)
	);

	qkp_readout u_readout (
		.count (count),
		.cfg   (cfg_q),
		.view  (view)
	);

	assign out_ch.valid = valid_s3;
	assign out_ch.data  = out_s3;

	// The count moves only when an item leaves the input register.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!update |=> $stable(count))
		else $error("count changed without an item");

	// An item leaving the input register always lands in the count stage.
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		update |=> valid_s2)
		else $error("item lost between input register and count stage");

	// A stalled result is never dropped.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_ch.ready |=> valid_s3 && $stable(out_s3))
		else $error("stalled result dropped or changed");

	// Every delivered transaction carries a ring pass and band in range.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (out_s3.revolution != 2'd0) && (out_s3.vibration_level <= 3'd4))
		else $error("result field out of range");

endmodule

/* test/tb_quadrature_knob_position_tracker.sv */
module tb_quadrature_knob_position_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import qkp_pkg::*;

	localparam int MAX_RING = 64;
	localparam int DUTY_W = 8;
	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		qkp_in_t  item;
		logic     typed;
		qkp_out_t result;
	} knob_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	qkp_in_if in_ch();
	qkp_out_if out_ch();

	quadrature_knob_position_tracker #(
		.MAX_RING_PIXELS(MAX_RING),
		.DUTY_BITS(DUTY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Shadow of the configuration and of the tracker state.
	logic [6:0] cfg_ring = 7'd24;
	logic [7:0] cfg_target = 8'd0;
	logic [7:0] cfg_band = 8'd2;
	logic [7:0] cfg_stride = 8'd5;
	logic [39:0] cfg_duties = 40'd0;
	int unsigned knob_count = 0;
	logic [1:0] last_phase = 2'b00;

	qkp_out_t pending_positions[$];
	int mismatches = 0;
	int unsigned cycles = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	bit hold_request = 1'b0;
	bit heading_up = 1'b1;

	logic [1:0] phase_up[4] = '{2'b10, 2'b00, 2'b11, 2'b01};
	logic [1:0] phase_down[4] = '{2'b01, 2'b11, 2'b00, 2'b10};

	always #6 clk = ~clk;

	function automatic int unsigned ring_size();
		if (cfg_ring == 0)
			return 1;
		if (cfg_ring > MAX_RING)
			return MAX_RING;
		return cfg_ring;
	endfunction

	function automatic int unsigned count_ceiling();
		int unsigned top;
		top = ring_size() * RINGS * STEPS_PER_DETENT;
		return (top > COUNT_LIMIT) ? COUNT_LIMIT : top;
	endfunction

	function automatic qkp_out_t advance_tracker(qkp_in_t it);
		int unsigned ring, top, quarter, detent, offset, gap, level;
		logic [1:0] rev;
		logic [3:0] move;
		qkp_out_t r;
		ring = ring_size();
		top = count_ceiling();
		if (it.mode == MODE_SAMPLE) begin
			move = {last_phase, it.pin_a, it.pin_b};
			case (move)
				STEP_UP_0, STEP_UP_1, STEP_UP_2, STEP_UP_3: knob_count++;
				STEP_DOWN_0, STEP_DOWN_1, STEP_DOWN_2, STEP_DOWN_3: begin
					if (knob_count > 0)
						knob_count--;
				end
				default: ;
			endcase
			last_phase = {it.pin_a, it.pin_b};
			if (knob_count > top)
				knob_count = top;
		end else begin
			knob_count = (it.preset_count > top) ? top : it.preset_count;
			if (it.clear_phase)
				last_phase = 2'b00;
		end
		quarter = knob_count / STEPS_PER_DETENT;
		detent = quarter;
		if (quarter < ring) begin
			rev = 2'd1;
			offset = quarter;
		end else if (quarter < 2 * ring) begin
			rev = 2'd2;
			offset = quarter - ring;
		end else if (quarter < 3 * ring) begin
			rev = 2'd3;
			offset = quarter - 2 * ring;
		end else begin
			detent = 3 * ring - 1;
			rev = 2'd3;
			offset = ring - 1;
		end
		gap = (cfg_target > quarter) ? cfg_target - quarter : quarter - cfg_target;
		if (gap < cfg_band)
			level = 0;
		else if (gap < cfg_band + cfg_stride)
			level = 1;
		else if (gap < cfg_band + 2 * cfg_stride)
			level = 2;
		else if (gap < cfg_band + 3 * cfg_stride)
			level = 3;
		else
			level = 4;
		r.raw_count = 10'(knob_count);
		r.detent_value = 8'(detent);
		r.revolution = rev;
		r.lit_pixel = 6'(ring - offset - 1);
		r.vibration_level = 3'(level);
		r.vibration_duty = 8'((cfg_duties >> (8 * level)) & ((40'd1 << DUTY_W) - 1));
		return r;
	endfunction

	function automatic knob_row_t pin_row(bit a, bit b);
		knob_row_t r;
		r = '0;
		r.item.mode = MODE_SAMPLE;
		r.item.pin_a = a;
		r.item.pin_b = b;
		return r;
	endfunction

	function automatic knob_row_t load_row(logic [9:0] preset, bit clr, bit a, bit b);
		knob_row_t r;
		r = pin_row(a, b);
		r.item.mode = MODE_LOAD;
		r.item.preset_count = preset;
		r.item.clear_phase = clr;
		return r;
	endfunction

	function automatic knob_row_t with_result(knob_row_t r, logic [9:0] rc, logic [7:0] det,
			logic [1:0] rev, logic [5:0] lit, logic [2:0] lvl, logic [7:0] duty);
		r.typed = 1'b1;
		r.result = '{rc, det, rev, lit, lvl, duty};
		return r;
	endfunction

	function automatic qkp_in_t random_item();
		qkp_in_t it;
		int unsigned roll;
		logic [1:0] nxt;
		it = qkp_in_t'($urandom);
		roll = $urandom_range(99);
		if ($urandom_range(99) < 4)
			heading_up = !heading_up;
		if (roll < 7) begin
			it.mode = MODE_LOAD;
			if (roll < 4)
				it.preset_count = 10'($urandom_range(count_ceiling()));
		end else begin
			it.mode = MODE_SAMPLE;
			if (roll < 88)
				nxt = heading_up ? phase_up[last_phase] : phase_down[last_phase];
			else if (roll < 94)
				nxt = last_phase;
			else
				nxt = last_phase ^ 2'b11;
			{it.pin_a, it.pin_b} = nxt;
		end
		return it;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_result(qkp_out_t got);
		qkp_out_t want;
		if (pending_positions.size() == 0) begin
			report_mismatch("result transaction with nothing expected");
			return;
		end
		want = pending_positions.pop_front();
		if (got.raw_count !== want.raw_count)
			report_mismatch($sformatf("raw_count %0d, expected %0d",
				got.raw_count, want.raw_count));
		if (got.detent_value !== want.detent_value)
			report_mismatch($sformatf("detent_value %0d, expected %0d",
				got.detent_value, want.detent_value));
		if (got.revolution !== want.revolution)
			report_mismatch($sformatf("revolution %0d, expected %0d",
				got.revolution, want.revolution));
		if (got.lit_pixel !== want.lit_pixel)
			report_mismatch($sformatf("lit_pixel %0d, expected %0d",
				got.lit_pixel, want.lit_pixel));
		if (got.vibration_level !== want.vibration_level)
			report_mismatch($sformatf("vibration_level %0d, expected %0d",
				got.vibration_level, want.vibration_level));
		if (got.vibration_duty !== want.vibration_duty)
			report_mismatch($sformatf("vibration_duty %0d, expected %0d",
				got.vibration_duty, want.vibration_duty));
	endtask

	task automatic issue(qkp_in_t it, logic typed, qkp_out_t typed_result);
		qkp_out_t predicted;
		predicted = advance_tracker(it);
		pending_positions.push_back(typed ? typed_result : predicted);
		while ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		case (index)
			REG_RING_PIXELS: cfg_ring = value[6:0];
			REG_TARGET_POSITION: cfg_target = value[7:0];
			REG_ANSWER_BAND: cfg_band = value[7:0];
			REG_BAND_STEP: cfg_stride = value[7:0];
			REG_STRENGTH_TABLE: cfg_duties = value[39:0];
			default: ;
		endcase
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_positions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			check_result(out_ch.data);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	initial begin
		knob_row_t walk[$];
		int regime, ph;
		logic [6:0] ring;
		logic [7:0] target, band, stride;
		logic [39:0] duties;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		walk = '{
			with_result(pin_row(0, 0), 10'd0, 8'd0, 2'd1, 6'd23, 3'd0, 8'd0),
			pin_row(1, 0), pin_row(1, 1), pin_row(0, 1), pin_row(0, 0),
			pin_row(0, 1), pin_row(1, 1), pin_row(1, 0), pin_row(0, 0),
			pin_row(0, 1), pin_row(0, 1), pin_row(1, 0), pin_row(0, 1), pin_row(1, 1),
			with_result(load_row(10'd768, 0, 0, 0), 10'd288, 8'd71, 2'd3, 6'd0, 3'd4, 8'd0),
			pin_row(0, 1),
			with_result(load_row(10'd0, 1, 0, 0), 10'd0, 8'd0, 2'd1, 6'd23, 3'd0, 8'd0),
			pin_row(1, 0),
			with_result(load_row(10'd1023, 1, 1, 1), 10'd288, 8'd71, 2'd3, 6'd0, 3'd4, 8'd0),
			pin_row(0, 0),
			load_row(10'd500, 0, 0, 1),
			load_row(10'd85, 0, 1, 0)
		};
		foreach (walk[i])
			issue(walk[i].item, walk[i].typed, walk[i].result);

		for (regime = 0; regime < 3; regime++) begin
			tx_idle = (regime == 0) ? 37 : (regime == 1) ? 46 : 0;
			rx_idle = (regime == 0) ? 46 : (regime == 1) ? 37 : 0;
			for (ph = 0; ph < 5; ph++) begin
				settle();
				case (ph)
					0: ring = 7'd64;
					1: ring = 7'd1;
					2: ring = 7'd127;
					3: ring = 7'd0;
					default: ring = 7'($urandom_range(127));
				endcase
				write_reg(REG_RING_PIXELS, CFG_DATA_W'(ring));
				target = 8'($urandom_range(3 * ring_size()));
				band = 8'($urandom_range(4));
				stride = 8'($urandom_range(ring_size()));
				duties = 40'({$urandom, $urandom});
				if (ph == 2) begin
					target = 8'hFF;
					band = 8'hFF;
					stride = 8'hFF;
					duties = '1;
				end else if (ph == 3) begin
					target = 8'd0;
					band = 8'd0;
					stride = 8'd0;
					duties = '0;
				end
				write_reg(REG_TARGET_POSITION, CFG_DATA_W'(target));
				write_reg(REG_ANSWER_BAND, CFG_DATA_W'(band));
				write_reg(REG_BAND_STEP, CFG_DATA_W'(stride));
				write_reg(REG_STRENGTH_TABLE, CFG_DATA_W'(duties));
				cfg_we <= 1'b0;
				if (ph == 1)
					hold_request = 1'b1;
				repeat (100)
					issue(random_item(), 1'b0, '0);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_positions.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/qkp_pkg.sv
hw/rtl/qkp_in_if.sv
hw/rtl/qkp_out_if.sv
hw/rtl/qkp_counter.sv
hw/rtl/qkp_readout.sv
hw/rtl/quadrature_knob_position_tracker.sv
test/tb_quadrature_knob_position_tracker.sv
